[src/mvna_pkg.sv]
// Shared types and constants for the mesh vertex normal averager.
`default_nettype none

package mvna_pkg;

    // Field widths
    localparam int IDX_W    = 6;
    localparam int COORD_W  = 16;
    localparam int ACC_W    = 24;
    localparam int EDGE_W   = 17;
    localparam int VEC_W    = 36;
    localparam int SQ_W     = 32;
    localparam int LEN_W    = 34;
    localparam int Q_W      = 15;
    localparam int D2_W     = 30;
    localparam int PLO_W    = 47;
    localparam int CMP_W    = 65;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W  = 33;
    localparam int MUL_B_W  = 18;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    // Stream payload widths
    localparam int IN_DATA_W  = 120;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 56;

    // Memory entry widths
    localparam int POS_W = 3 * COORD_W;
    localparam int ACCS_W = 3 * ACC_W;

    // Unit length in Q1.14 and the top bit index of the search
    localparam logic [Q_W-1:0] UNIT_ONE = 15'd16384;
    localparam logic [3:0]     TOP_BIT  = 4'd14;

    // Accumulator saturation limits
    localparam logic signed [ACC_W:0] ACC_MAX = 25'sd8388607;
    localparam logic signed [ACC_W:0] ACC_MIN = -25'sd8388608;

    // Opcodes
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_TRI  = 2'd1;
    localparam logic [1:0] OP_NORM = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD_P0,
        ST_RD_P1,
        ST_RD_P2,
        ST_CAP_P2,
        ST_CROSS,
        ST_RD_ACC,
        ST_CAP_ACC,
        ST_MAG,
        ST_SHIFT,
        ST_SQ,
        ST_LEN,
        ST_DSQ,
        ST_PLO,
        ST_PHI,
        ST_CMP,
        ST_AC_RD,
        ST_AC_WR,
        ST_WB,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

[src/mvna_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mvna_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[src/mesh_vertex_normal_averager.sv]
// Mesh vertex normal averager: per-vertex position and normal accumulator store.
//
// Input stream (s_axis): one transaction per command. tuser carries the opcode
// (load vertex, add triangle, normalize vertex); tdata carries the three vertex
// indices, the Q3.12 position and the Q1.14 starting normal.
// Output stream (m_axis): one transaction per normalize command, carrying the
// vertex index and its Q1.14 unit normal.
//
// Timing: a load is written in the accepting cycle. Triangles and normalizes run
// through a single shared multiplier: a bit-by-bit search of 15 steps for each of
// the three unit components dominates, after a magnitude prescaling pass. A
// degenerate triangle returns to idle before the search. One command is processed
// at a time; s_axis_tready is high while the engine is free.
//
// Reset clears the control state only; both vertex memories are undefined
// until loaded, with no clearing pass. The result sits in an output register,
// so a stalled receiver does not block the next command; only a following
// normalize waits for the output register to drain.
`default_nettype none

module mesh_vertex_normal_averager
    import mvna_pkg::*;
#(
    parameter int VERTICES = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [5:0] vertex_index, [11:6] second_index, [17:12] third_index,
    // [33:18] pos_x, [49:34] pos_y, [65:50] pos_z,
    // [81:66] init_nx, [97:82] init_ny, [113:98] init_nz, rest zero
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] opcode
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [5:0] out_index, [21:6] normal_x, [37:22] normal_y, [53:38] normal_z,
    // rest zero
    output logic      [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int AW = (VERTICES > 1) ? $clog2(VERTICES) : 1;

    // Control state
    t_state r_state, n_state;
    logic   r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    // Datapath registers
    logic [1:0]                    r_op;
    logic [IDX_W-1:0]              r_idx   [3];
    logic [POS_W-1:0]              r_p0;
    logic signed [EDGE_W-1:0]      r_e1    [3];
    logic signed [EDGE_W-1:0]      r_e2    [3];
    logic signed [VEC_W-1:0]       r_vec   [3];
    logic [VEC_W-1:0]              r_mag   [3];
    logic                          r_neg   [3];
    logic [SQ_W-1:0]               r_sq    [3];
    logic [LEN_W-1:0]              r_len;
    logic [2:0]                    r_cnt;
    logic [1:0]                    r_comp;
    logic [1:0]                    r_corner;
    logic [3:0]                    r_bit;
    logic [Q_W-1:0]                r_q;
    logic [Q_W-1:0]                r_res   [3];
    logic [D2_W-1:0]               r_d2;
    logic [PLO_W-1:0]              r_plo;
    logic signed [PROD_W-1:0]      r_prod;

    // Memory ports
    logic              pos_we, acc_we;
    logic [AW-1:0]     pos_waddr, pos_raddr, acc_waddr, acc_raddr;
    logic [POS_W-1:0]  pos_wdata, pos_rdata;
    logic [ACCS_W-1:0] acc_wdata, acc_rdata;

    // Shared multiplier operands
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;

    // Input field decode
    logic                 in_accept;
    logic [IDX_W-1:0]     in_i0, in_i1, in_i2;
    logic                 ok0, ok1, ok2;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_i0 = s_axis_tdata[5:0];
    assign in_i1 = s_axis_tdata[11:6];
    assign in_i2 = s_axis_tdata[17:12];
    assign ok0 = (32'(in_i0) < VERTICES);
    assign ok1 = (32'(in_i1) < VERTICES);
    assign ok2 = (32'(in_i2) < VERTICES);

    assign s_axis_tready = (r_state == ST_IDLE);

    // Search candidate and its comparison terms
    logic [Q_W-1:0]          trial;
    logic [Q_W:0]            odd;
    logic [CMP_W-1:0]        lhs, rhs;
    logic                    take;
    logic                    any_big, all_zero;

    assign trial = r_q | (Q_W'(1) << r_bit);
    assign odd   = {trial, 1'b0} - (Q_W+1)'(1);
    assign lhs   = CMP_W'({r_prod[PLO_W-1:0], 17'd0}) + CMP_W'(r_plo);
    assign rhs   = CMP_W'({r_sq[r_comp], 30'd0});
    assign take  = (trial <= UNIT_ONE) && (lhs <= rhs);

    always_comb begin
        any_big  = 1'b0;
        all_zero = 1'b1;
        for (int k = 0; k < 3; k++) begin
            any_big  = any_big  | (|r_mag[k][VEC_W-1:16]);
            all_zero = all_zero & (r_mag[k] == '0);
        end
    end

    // Signed unit normal from magnitudes and signs
    logic signed [COORD_W-1:0] nrm [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            nrm[k] = r_neg[k] ? -$signed({1'b0, r_res[k]}) : $signed({1'b0, r_res[k]});
        end
    end

    // Saturating accumulate for the current corner
    logic signed [ACC_W:0]   sum   [3];
    logic [ACCS_W-1:0]       acc_sat;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum[k] = (ACC_W+1)'($signed(acc_rdata[k*ACC_W +: ACC_W]))
                   + (ACC_W+1)'(nrm[k]);
            if (sum[k] > ACC_MAX) begin
                acc_sat[k*ACC_W +: ACC_W] = ACC_MAX[ACC_W-1:0];
            end else if (sum[k] < ACC_MIN) begin
                acc_sat[k*ACC_W +: ACC_W] = ACC_MIN[ACC_W-1:0];
            end else begin
                acc_sat[k*ACC_W +: ACC_W] = sum[k][ACC_W-1:0];
            end
        end
    end

    // Cross product term selection
    logic [2:0] xstep;
    assign xstep = r_cnt - 3'd1;

    // Next state, memory control and multiplier operands
    always_comb begin
        n_state   = r_state;
        pos_we    = 1'b0;
        acc_we    = 1'b0;
        pos_waddr = AW'(in_i0);
        pos_wdata = s_axis_tdata[65:18];
        acc_waddr = AW'(in_i0);
        acc_wdata = {ACC_W'($signed(s_axis_tdata[113:98])),
                     ACC_W'($signed(s_axis_tdata[97:82])),
                     ACC_W'($signed(s_axis_tdata[81:66]))};
        pos_raddr = AW'(r_idx[0]);
        acc_raddr = AW'(r_idx[0]);
        mul_a     = '0;
        mul_b     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    priority case (s_axis_tuser)
                        OP_LOAD: begin
                            pos_we = ok0;
                            acc_we = ok0;
                        end
                        OP_TRI: begin
                            if (ok0 && ok1 && ok2) begin
                                n_state = ST_RD_P0;
                            end
                        end
                        OP_NORM: begin
                            n_state = ok0 ? ST_RD_ACC : ST_OUT;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_RD_P0: begin
                pos_raddr = AW'(r_idx[0]);
                n_state   = ST_RD_P1;
            end
            ST_RD_P1: begin
                pos_raddr = AW'(r_idx[1]);
                n_state   = ST_RD_P2;
            end
            ST_RD_P2: begin
                pos_raddr = AW'(r_idx[2]);
                n_state   = ST_CAP_P2;
            end
            ST_CAP_P2: n_state = ST_CROSS;
            ST_CROSS: begin
                // c0 = e1y*e2z - e1z*e2y, c1 = e1z*e2x - e1x*e2z, c2 = e1x*e2y - e1y*e2x
                unique case (r_cnt)
                    3'd0: begin mul_a = MUL_A_W'(r_e1[1]); mul_b = MUL_B_W'(r_e2[2]); end
                    3'd1: begin mul_a = MUL_A_W'(r_e1[2]); mul_b = MUL_B_W'(r_e2[1]); end
                    3'd2: begin mul_a = MUL_A_W'(r_e1[2]); mul_b = MUL_B_W'(r_e2[0]); end
                    3'd3: begin mul_a = MUL_A_W'(r_e1[0]); mul_b = MUL_B_W'(r_e2[2]); end
                    3'd4: begin mul_a = MUL_A_W'(r_e1[0]); mul_b = MUL_B_W'(r_e2[1]); end
                    3'd5: begin mul_a = MUL_A_W'(r_e1[1]); mul_b = MUL_B_W'(r_e2[0]); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
                if (r_cnt == 3'd6) begin
                    n_state = ST_MAG;
                end
            end
            ST_RD_ACC: begin
                acc_raddr = AW'(r_idx[0]);
                n_state   = ST_CAP_ACC;
            end
            ST_CAP_ACC: n_state = ST_MAG;
            ST_MAG:     n_state = ST_SHIFT;
            ST_SHIFT: begin
                if (all_zero) begin
                    n_state = (r_op == OP_TRI) ? ST_IDLE : ST_WB;
                end else if (!any_big) begin
                    n_state = ST_SQ;
                end
            end
            ST_SQ: begin
                if (r_cnt < 3'd3) begin
                    mul_a = MUL_A_W'({1'b0, r_mag[r_cnt[1:0]][15:0]});
                    mul_b = MUL_B_W'({1'b0, r_mag[r_cnt[1:0]][15:0]});
                end else begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: n_state = ST_DSQ;
            ST_DSQ: begin
                mul_a   = MUL_A_W'(odd);
                mul_b   = MUL_B_W'(odd);
                n_state = ST_PLO;
            end
            ST_PLO: begin
                mul_a   = MUL_A_W'(r_prod[D2_W-1:0]);
                mul_b   = MUL_B_W'(r_len[16:0]);
                n_state = ST_PHI;
            end
            ST_PHI: begin
                mul_a   = MUL_A_W'(r_d2);
                mul_b   = MUL_B_W'(r_len[LEN_W-1:17]);
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (r_bit != 4'd0 || r_comp != 2'd2) begin
                    n_state = ST_DSQ;
                end else begin
                    n_state = (r_op == OP_TRI) ? ST_AC_RD : ST_WB;
                end
            end
            ST_AC_RD: begin
                acc_raddr = AW'(r_idx[r_corner]);
                n_state   = ST_AC_WR;
            end
            ST_AC_WR: begin
                acc_we    = 1'b1;
                acc_waddr = AW'(r_idx[r_corner]);
                acc_wdata = acc_sat;
                n_state   = (r_corner == 2'd2) ? ST_IDLE : ST_AC_RD;
            end
            ST_WB: begin
                acc_we    = 1'b1;
                acc_waddr = AW'(r_idx[0]);
                acc_wdata = {ACC_W'(nrm[2]), ACC_W'(nrm[1]), ACC_W'(nrm[0])};
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    r_op     <= s_axis_tuser;
                    r_idx[0] <= in_i0;
                    r_idx[1] <= in_i1;
                    r_idx[2] <= in_i2;
                    for (int k = 0; k < 3; k++) begin
                        r_res[k] <= '0;
                        r_neg[k] <= 1'b0;
                    end
                end
            end
            ST_RD_P1: r_p0 <= pos_rdata;
            ST_RD_P2: begin
                for (int k = 0; k < 3; k++) begin
                    r_e1[k] <= EDGE_W'($signed(pos_rdata[k*COORD_W +: COORD_W]))
                             - EDGE_W'($signed(r_p0[k*COORD_W +: COORD_W]));
                end
            end
            ST_CAP_P2: begin
                for (int k = 0; k < 3; k++) begin
                    r_e2[k] <= EDGE_W'($signed(pos_rdata[k*COORD_W +: COORD_W]))
                             - EDGE_W'($signed(r_p0[k*COORD_W +: COORD_W]));
                end
                r_cnt <= '0;
            end
            ST_CROSS: begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt != 3'd0) begin
                    if (!xstep[0]) begin
                        r_vec[xstep[2:1]] <= VEC_W'(r_prod);
                    end else begin
                        r_vec[xstep[2:1]] <= r_vec[xstep[2:1]] - VEC_W'(r_prod);
                    end
                end
            end
            ST_CAP_ACC: begin
                for (int k = 0; k < 3; k++) begin
                    r_vec[k] <= VEC_W'($signed(acc_rdata[k*ACC_W +: ACC_W]));
                end
            end
            ST_MAG: begin
                for (int k = 0; k < 3; k++) begin
                    r_neg[k] <= r_vec[k][VEC_W-1];
                    r_mag[k] <= r_vec[k][VEC_W-1] ? VEC_W'(-r_vec[k]) : VEC_W'(r_vec[k]);
                end
            end
            ST_SHIFT: begin
                // Truncate all magnitudes until the largest fits in 16 bits
                if (any_big) begin
                    for (int k = 0; k < 3; k++) begin
                        r_mag[k] <= r_mag[k] >> 1;
                    end
                end
                r_cnt <= '0;
            end
            ST_SQ: begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt != 3'd0) begin
                    r_sq[xstep[1:0]] <= r_prod[SQ_W-1:0];
                end
            end
            ST_LEN: begin
                r_len  <= LEN_W'(r_sq[0]) + LEN_W'(r_sq[1]) + LEN_W'(r_sq[2]);
                r_comp <= '0;
                r_bit  <= TOP_BIT;
                r_q    <= '0;
            end
            ST_PLO: r_d2 <= r_prod[D2_W-1:0];
            ST_PHI: r_plo <= r_prod[PLO_W-1:0];
            ST_CMP: begin
                // Keep the candidate bit when (2t-1)^2 * L <= a^2 * 2^30 and t does not exceed one
                if (r_bit == 4'd0) begin
                    r_res[r_comp] <= take ? trial : r_q;
                    r_q           <= '0;
                    r_bit         <= TOP_BIT;
                    r_comp        <= r_comp + 2'd1;
                end else begin
                    if (take) begin
                        r_q <= trial;
                    end
                    r_bit <= r_bit - 4'd1;
                end
                r_corner <= '0;
            end
            ST_AC_WR: r_corner <= r_corner + 2'd1;
            default: begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && (!r_out_valid || m_axis_tready)) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && (!r_out_valid || m_axis_tready)) begin
            r_out_data <= {2'd0, nrm[2], nrm[1], nrm[0], r_idx[0]};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Vertex position store
    mvna_ram #(
        .WIDTH (POS_W),
        .DEPTH (VERTICES)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (pos_waddr),
        .i_wdata (pos_wdata),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    // Normal accumulator store
    mvna_ram #(
        .WIDTH (ACCS_W),
        .DEPTH (VERTICES)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (acc_waddr),
        .i_wdata (acc_wdata),
        .i_raddr (acc_raddr),
        .o_rdata (acc_rdata)
    );

    // Squares are only taken once every magnitude fits in 16 bits
    a_sq_prescaled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQ) |-> !any_big)
        else $error("magnitude not prescaled before squaring");

    // Unit components never exceed one in Q1.14
    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> (r_res[0] <= UNIT_ONE && r_res[1] <= UNIT_ONE
                                 && r_res[2] <= UNIT_ONE))
        else $error("unit component above one");

    // Accumulator writes from idle come only from an accepted load
    a_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_we && r_state == ST_IDLE) |-> (in_accept && s_axis_tuser == OP_LOAD))
        else $error("accumulator write without load");

    // Corner update loop stays within the three corners
    a_corner_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_AC_RD || r_state == ST_AC_WR) |-> (r_corner != 2'd3))
        else $error("corner counter out of range");

    // A result is loaded only when the output register is free or draining
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && r_out_valid && !m_axis_tready) |=> (r_state == ST_OUT))
        else $error("result left while output register busy");

endmodule

`default_nettype wire
